// ===== design/kpc_pkg.sv =====
// kpc_pkg: shared types and constants of the key press classifier.
// Used by kpc_core and key_press_classifier; depends on nothing.
`timescale 1ns / 1ps

package kpc_pkg;

	localparam int TimerW  = 16;
	localparam int CfgIdxW = 3;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_ACTIVE_LOW    = 3'd0,
		CFG_HOLD_MS       = 3'd1,
		CFG_LONG_MS       = 3'd2,
		CFG_DOUBLE_WIN_MS = 3'd3,
		CFG_SINGLE_TO_MS  = 3'd4
	} cfg_idx_t;

	// reset values of the configuration registers
	localparam logic              RstActiveLow   = 1'b1;
	localparam logic [TimerW-1:0] RstHoldMs      = 16'd2000;
	localparam logic [TimerW-1:0] RstLongMs      = 16'd1500;
	localparam logic [TimerW-1:0] RstDoubleWinMs = 16'd1200;
	localparam logic [TimerW-1:0] RstSingleToMs  = 16'd250;

	// event flag codes: bit0 long, bit1 single, bit2 double
	localparam logic [2:0] EvNone   = 3'b000;
	localparam logic [2:0] EvLong   = 3'b001;
	localparam logic [2:0] EvSingle = 3'b010;
	localparam logic [2:0] EvDouble = 3'b100;

	localparam logic [1:0] PendMax = 2'd3;
	localparam logic [1:0] PendOne = 2'd1;

	typedef struct packed {
		logic              active_low;
		logic [TimerW-1:0] hold_ms;
		logic [TimerW-1:0] long_ms;
		logic [TimerW-1:0] double_window_ms;
		logic [TimerW-1:0] single_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic       btn_down;
		logic       held_long;
		logic [2:0] events;
	} res_t;

	function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

endpackage

// ===== design/key_press_classifier.sv =====
// key_press_classifier: top level; config registers, core, result register.
// Depends on kpc_pkg and kpc_core.
//
// Usage:
//   Input channel (in_valid/in_ready, cmd, key_level): cmd=0 is a 1 ms tick,
//   cmd=1 is a sample of the raw key pin in key_level.
//   Output channel (out_valid/out_ready): one result per input transaction
//   giving btn_down, held_long and the sticky long/single/double flags as
//   they stand after that transaction.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 active_low, 1 hold_ms, 2 long_ms, 3 double_window_ms,
//   4 single_timeout_ms. Other indexes are dropped. Write only when idle.
// Timing:
//   out_valid rises in the cycle after the input transaction. One item per
//   cycle is taken; the single result register sets the rate, and a new item
//   enters whenever that register is empty or being read in the same cycle.
// Reset: clears all press state, flags and out_valid; config returns to
//   active_low=1, 2000/1500/1200/250 ms.
// Stall: while out_ready is low and a result waits, in_ready is low.
`timescale 1ns / 1ps

module key_press_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic                        key_level,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        btn_down,
	output logic                        held_long,
	output logic                        long_press,
	output logic                        single_press,
	output logic                        double_press,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kpc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [kpc_pkg::TimerW-1:0]  cfg_data
);

	kpc_pkg::cfg_t cfg_q;
	kpc_pkg::res_t res_c, res_q;
	logic          out_valid_q;
	logic          in_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~out_valid_q | out_ready;
	assign in_acc    = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low        <= kpc_pkg::RstActiveLow;
			cfg_q.hold_ms           <= kpc_pkg::RstHoldMs;
			cfg_q.long_ms           <= kpc_pkg::RstLongMs;
			cfg_q.double_window_ms  <= kpc_pkg::RstDoubleWinMs;
			cfg_q.single_timeout_ms <= kpc_pkg::RstSingleToMs;
		end else if (cfg_valid) begin
			case (kpc_pkg::cfg_idx_t'(cfg_index))
				kpc_pkg::CFG_ACTIVE_LOW:    cfg_q.active_low        <= cfg_data[0];
				kpc_pkg::CFG_HOLD_MS:       cfg_q.hold_ms           <= cfg_data;
				kpc_pkg::CFG_LONG_MS:       cfg_q.long_ms           <= cfg_data;
				kpc_pkg::CFG_DOUBLE_WIN_MS: cfg_q.double_window_ms  <= cfg_data;
				kpc_pkg::CFG_SINGLE_TO_MS:  cfg_q.single_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	kpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_acc),
		.cmd       (cmd),
		.key_level (key_level),
		.cfg       (cfg_q),
		.res       (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			res_q <= res_c;
	end

	assign out_valid    = out_valid_q;
	assign btn_down     = res_q.btn_down;
	assign held_long    = res_q.held_long;
	assign long_press   = res_q.events[0];
	assign single_press = res_q.events[1];
	assign double_press = res_q.events[2];

endmodule

// ===== design/kpc_core.sv =====
// kpc_core: classifier state and its one-step update for each transaction.
// Depends on kpc_pkg for the config/result structs and event codes.
`timescale 1ns / 1ps

module kpc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           cmd,
	input  logic           key_level,
	input  kpc_pkg::cfg_t  cfg,
	output kpc_pkg::res_t  res
);

	logic                       down_q, held_q, gap_run_q;
	logic [kpc_pkg::TimerW-1:0] hold_tmr_q, gap_tmr_q;
	logic [1:0]                 pend_q;
	logic [2:0]                 ev_q;

	logic                       down_d, held_d, gap_run_d;
	logic [kpc_pkg::TimerW-1:0] hold_tmr_d, gap_tmr_d, gap_inc;
	logic [1:0]                 pend_d;
	logic [2:0]                 ev_d;
	logic                       pressed;

	assign pressed = cfg.active_low ? ~key_level : key_level;
	assign gap_inc = kpc_pkg::sat_inc(gap_tmr_q);

	always_comb begin
		down_d     = down_q;
		held_d     = held_q;
		gap_run_d  = gap_run_q;
		hold_tmr_d = hold_tmr_q;
		gap_tmr_d  = gap_tmr_q;
		pend_d     = pend_q;
		ev_d       = ev_q;
		if (!cmd) begin
			// millisecond tick
			if (down_q)
				hold_tmr_d = kpc_pkg::sat_inc(hold_tmr_q);
			if (gap_run_q) begin
				gap_tmr_d = gap_inc;
				if (gap_inc >= cfg.single_timeout_ms) begin
					gap_run_d = 1'b0;
					pend_d    = 2'd0;
					ev_d      = kpc_pkg::EvSingle;
				end
			end
		end else if (pressed) begin
			if (!down_q) begin
				down_d     = 1'b1;
				hold_tmr_d = '0;
			end else if (hold_tmr_q >= cfg.hold_ms) begin
				held_d = 1'b1;
			end
		end else if (down_q) begin
			// release: classify the press
			down_d = 1'b0;
			held_d = 1'b0;
			if (hold_tmr_q >= cfg.long_ms) begin
				ev_d = kpc_pkg::EvLong;
			end else if (pend_q == kpc_pkg::PendOne && gap_tmr_q <= cfg.double_window_ms) begin
				pend_d    = 2'd0;
				gap_run_d = 1'b0;
				ev_d      = kpc_pkg::EvDouble;
			end else begin
				gap_tmr_d = '0;
				gap_run_d = 1'b1;
				if (pend_q != kpc_pkg::PendMax)
					pend_d = pend_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q     <= 1'b0;
			held_q     <= 1'b0;
			gap_run_q  <= 1'b0;
			hold_tmr_q <= '0;
			gap_tmr_q  <= '0;
			pend_q     <= 2'd0;
			ev_q       <= kpc_pkg::EvNone;
		end else if (step) begin
			down_q     <= down_d;
			held_q     <= held_d;
			gap_run_q  <= gap_run_d;
			hold_tmr_q <= hold_tmr_d;
			gap_tmr_q  <= gap_tmr_d;
			pend_q     <= pend_d;
			ev_q       <= ev_d;
		end
	end

	// state after this transaction, for the result register
	assign res.btn_down  = down_d;
	assign res.held_long = held_d;
	assign res.events    = ev_d;

endmodule

// ===== design/kpc_chk.sv =====
// kpc_chk: port-level checks of key_press_classifier, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module kpc_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic btn_down,
	input logic held_long,
	input logic long_press,
	input logic single_press,
	input logic double_press
);

	// held_long only while the key is down
	a_held_needs_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!held_long || btn_down))
		else $error("held_long without btn_down");

	// sticky events are mutually exclusive
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({long_press, single_press, double_press}))
		else $error("more than one event flag set");

	// every accepted transaction yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("no result after input transaction");

	// a waiting result holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable({btn_down, held_long,
			long_press, single_press, double_press})))
		else $error("pending result changed");

endmodule

bind key_press_classifier kpc_chk u_kpc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.btn_down     (btn_down),
	.held_long    (held_long),
	.long_press   (long_press),
	.single_press (single_press),
	.double_press (double_press)
);

// ===== dv/tb_key_press_classifier.sv =====
// tb_key_press_classifier: self-checking bench for key_press_classifier. A directed
// table and then randomized press gestures; every result is checked against a pinned
// value or an in-bench classifier. Depends on kpc_pkg and the key_press_classifier RTL.
`timescale 1ns / 1ps

module tb_key_press_classifier;

	localparam int IdxW = kpc_pkg::CfgIdxW;
	localparam int TmrW = kpc_pkg::TimerW;

	localparam logic CmdTick   = 1'b0;
	localparam logic CmdSample = 1'b1;

	localparam logic [IdxW-1:0] CfgIdxSpare = IdxW'(kpc_pkg::CFG_SINGLE_TO_MS) + 1'b1;

	localparam int unsigned RandItems  = 1700;
	localparam int unsigned PhaseItems = 120;
	localparam int          DirRows    = 31;

	typedef enum logic {RowItem, RowReg} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              c;
		logic              lv;
		logic [IdxW-1:0]   idx;
		logic [TmrW-1:0]   data;
		logic              pinned;
		kpc_pkg::res_t     want;
	} dir_row_t;

	typedef struct {
		bit            pinned;
		kpc_pkg::res_t want;
	} item_note_t;

	typedef struct {
		logic            down;
		logic            held;
		logic [TmrW-1:0] hold_cnt;
		logic [TmrW-1:0] gap_cnt;
		logic            gap_on;
		logic [1:0]      pend;
		logic [2:0]      ev;
	} press_state_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              cmd       = 1'b0;
	logic              key_level = 1'b0;
	logic              out_ready = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [IdxW-1:0]   cfg_index = '0;
	logic [TmrW-1:0]   cfg_data  = '0;
	logic in_ready, out_valid, cfg_ready;
	logic btn_down, held_long, long_press, single_press, double_press;

	press_state_t    kstate;
	kpc_pkg::cfg_t   kcfg;
	kpc_pkg::res_t   flags_due[$];
	item_note_t      item_notes[$];
	kpc_pkg::res_t   got_res, exp_res, pred_res;
	item_note_t      note;

	int unsigned n_err, n_sent, n_checked, n_writes;
	int unsigned n_long, n_single, n_double;
	int unsigned in_gap_odds, out_stall_odds;

	string field_names[5] = '{"long_press", "single_press", "double_press", "held_long",
		"btn_down"};

	// pinned rows: default polarity (key reads 0 when pressed), no timer threshold reachable
	dir_row_t dir_rows[DirRows] = '{
		'{RowItem, CmdTick,   1'b0, '0, '0, 1'b1, {1'b0, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b1, {1'b0, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b1, {1'b1, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b1, {1'b1, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdTick,   1'b1, '0, '0, 1'b1, {1'b1, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b1, {1'b0, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b1, {1'b1, 1'b0, kpc_pkg::EvNone}},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b1, {1'b0, 1'b0, kpc_pkg::EvDouble}},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b1, {1'b1, 1'b0, kpc_pkg::EvDouble}},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b1, {1'b0, 1'b0, kpc_pkg::EvDouble}},
		'{RowItem, CmdTick,   1'b0, '0, '0, 1'b0, '0},
		// active-high key, zero thresholds except long
		'{RowReg,  1'b0, 1'b0, kpc_pkg::CFG_ACTIVE_LOW,    16'h0000, 1'b0, '0},
		'{RowReg,  1'b0, 1'b0, kpc_pkg::CFG_HOLD_MS,       16'h0000, 1'b0, '0},
		'{RowReg,  1'b0, 1'b0, kpc_pkg::CFG_LONG_MS,       16'hFFFF, 1'b0, '0},
		'{RowReg,  1'b0, 1'b0, kpc_pkg::CFG_DOUBLE_WIN_MS, 16'h0000, 1'b0, '0},
		'{RowReg,  1'b0, 1'b0, kpc_pkg::CFG_SINGLE_TO_MS,  16'h0000, 1'b0, '0},
		'{RowItem, CmdTick,   1'b0, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b0, '0},
		'{RowItem, CmdTick,   1'b1, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b0, '0},
		'{RowReg,  1'b0, 1'b0, kpc_pkg::CFG_LONG_MS,       16'h0000, 1'b0, '0},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b0, '0, '0, 1'b0, '0},
		// unmapped index must leave every register alone
		'{RowReg,  1'b0, 1'b0, CfgIdxSpare,                16'hFFFF, 1'b0, '0},
		'{RowItem, CmdTick,   1'b0, '0, '0, 1'b0, '0},
		'{RowItem, CmdSample, 1'b1, '0, '0, 1'b0, '0}
	};

	key_press_classifier i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.key_level   (key_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.btn_down    (btn_down),
		.held_long   (held_long),
		.long_press  (long_press),
		.single_press(single_press),
		.double_press(double_press),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report(input string msg);
		n_err++;
		if (n_err <= 40) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	function automatic logic [TmrW-1:0] bump(input logic [TmrW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic classify_item(input logic c, input logic lv, output kpc_pkg::res_t r);
		logic pressed;
		if (c == CmdTick) begin
			if (kstate.down) kstate.hold_cnt = bump(kstate.hold_cnt);
			if (kstate.gap_on) begin
				kstate.gap_cnt = bump(kstate.gap_cnt);
				if (kstate.gap_cnt >= kcfg.single_timeout_ms) begin
					kstate.gap_on = 1'b0;
					kstate.pend   = '0;
					kstate.ev     = kpc_pkg::EvSingle;
					n_single++;
				end
			end
		end else begin
			pressed = (lv != kcfg.active_low);
			if (pressed) begin
				if (!kstate.down) begin
					kstate.down     = 1'b1;
					kstate.hold_cnt = '0;
				end else if (kstate.hold_cnt >= kcfg.hold_ms) begin
					kstate.held = 1'b1;
				end
			end else if (kstate.down) begin
				kstate.down = 1'b0;
				kstate.held = 1'b0;
				if (kstate.hold_cnt >= kcfg.long_ms) begin
					kstate.ev = kpc_pkg::EvLong;
					n_long++;
				end else if (kstate.pend == kpc_pkg::PendOne &&
						kstate.gap_cnt <= kcfg.double_window_ms) begin
					kstate.pend   = '0;
					kstate.gap_on = 1'b0;
					kstate.ev     = kpc_pkg::EvDouble;
					n_double++;
				end else begin
					kstate.gap_cnt = '0;
					kstate.gap_on  = 1'b1;
					if (kstate.pend != kpc_pkg::PendMax) kstate.pend = kstate.pend + 1'b1;
				end
			end
		end
		r.btn_down  = kstate.down;
		r.held_long = kstate.held;
		r.events    = kstate.ev;
	endtask

	// transaction monitor: predicts on input, checks on output, tracks register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_res = {btn_down, held_long, double_press, single_press, long_press};
				if (flags_due.size() == 0) begin
					report("result transaction with nothing expected");
				end else begin
					exp_res = flags_due.pop_front();
					n_checked++;
					for (int i = 0; i < 5; i++) begin
						if (got_res[i] !== exp_res[i]) begin
							report($sformatf("result %0d: %s got %b want %b", n_checked,
								field_names[i], got_res[i], exp_res[i]));
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				note = item_notes.pop_front();
				classify_item(cmd, key_level, pred_res);
				flags_due.push_back(note.pinned ? note.want : pred_res);
			end
			if (cfg_valid && cfg_ready) begin
				n_writes++;
				case (cfg_index)
					kpc_pkg::CFG_ACTIVE_LOW:    kcfg.active_low        = cfg_data[0];
					kpc_pkg::CFG_HOLD_MS:       kcfg.hold_ms           = cfg_data;
					kpc_pkg::CFG_LONG_MS:       kcfg.long_ms           = cfg_data;
					kpc_pkg::CFG_DOUBLE_WIN_MS: kcfg.double_window_ms  = cfg_data;
					kpc_pkg::CFG_SINGLE_TO_MS:  kcfg.single_timeout_ms = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always begin
		@(posedge clk);
		if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	task automatic put_item(input logic c, input logic lv, input bit pinned = 1'b0,
			input kpc_pkg::res_t want = '0);
		item_note_t n;
		n.pinned = pinned;
		n.want   = want;
		item_notes.push_back(n);
		in_valid  <= 1'b1;
		cmd       <= c;
		key_level <= lv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
		if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		if (in_valid) in_valid <= 1'b0;
		while (item_notes.size() != 0 || flags_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [TmrW-1:0] val);
		wait_results_done();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned pick_odds();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 4;
			default: return 12;
		endcase
	endfunction

	function automatic logic [TmrW-1:0] pick_ms();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return TmrW'($urandom);
			default: return TmrW'($urandom_range(0, 24));
		endcase
	endfunction

	// keeps random hold and gap lengths near the thresholds without long tick runs
	function automatic int unsigned reach(input logic [TmrW-1:0] a,
			input logic [TmrW-1:0] b);
		int unsigned m;
		m = 32'((a > b) ? a : b);
		return (m > 56) ? 60 : m + 4;
	endfunction

	task automatic press_gesture();
		logic        p;
		int unsigned hold_n, gap_n;
		p = ~kcfg.active_low;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			hold_n = $urandom_range(0, reach(kcfg.hold_ms, kcfg.long_ms));
			gap_n  = $urandom_range(0, reach(kcfg.double_window_ms, kcfg.single_timeout_ms));
			put_item(CmdSample, p);
			repeat (hold_n) begin
				if ($urandom_range(0, 3) == 0) put_item(CmdSample, p);
				put_item(CmdTick, 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 1)) put_item(CmdSample, p);
			put_item(CmdSample, ~p);
			repeat (gap_n) begin
				if ($urandom_range(0, 7) == 0) put_item(CmdSample, ~p);
				put_item(CmdTick, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		#5_000_000;
		$display("tb_key_press_classifier NOT OK");
		$finish;
	end

	initial begin : stim
		int unsigned     n_rand, ph, start, w;
		logic [TmrW-1:0] d;

		kstate = '{default: '0};
		kcfg   = '{kpc_pkg::RstActiveLow, kpc_pkg::RstHoldMs, kpc_pkg::RstLongMs,
			kpc_pkg::RstDoubleWinMs, kpc_pkg::RstSingleToMs};
		in_gap_odds    = 0;
		out_stall_odds = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_gap_odds    = 5;
		out_stall_odds = 5;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == RowReg) begin
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				put_item(dir_rows[i].c, dir_rows[i].lv, dir_rows[i].pinned, dir_rows[i].want);
			end
		end

		// phase 0 takes every threshold at zero, phase 1 at full scale
		n_rand = 0;
		ph     = 0;
		start  = 0;
		while (n_rand < RandItems) begin
			if (n_rand + 300 >= RandItems) begin
				in_gap_odds    = 0;
				out_stall_odds = 0;
			end else begin
				in_gap_odds    = pick_odds();
				out_stall_odds = pick_odds();
			end
			d    = TmrW'($urandom);
			d[0] = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			write_reg(kpc_pkg::CFG_ACTIVE_LOW, d);
			for (int r = kpc_pkg::CFG_HOLD_MS; r <= kpc_pkg::CFG_SINGLE_TO_MS; r++) begin
				write_reg(IdxW'(r), (ph == 0) ? '0 : (ph == 1) ? '1 : pick_ms());
			end
			write_reg(CfgIdxSpare + IdxW'($urandom_range(0, 2)), TmrW'($urandom));
			start = n_sent;
			while (n_sent - start < PhaseItems) begin
				press_gesture();
				if ($urandom_range(0, 49) == 0) wait_results_done();
			end
			n_rand += n_sent - start;
			ph++;
		end

		if (in_valid) in_valid <= 1'b0;
		for (w = 0; w < 1000 && (item_notes.size() != 0 || flags_due.size() != 0); w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (flags_due.size() != 0) begin
			report($sformatf("%0d results never arrived", flags_due.size()));
		end

		$display("covered: %0d key transactions under %0d register setups, %0d writes, %0d checked",
			n_sent, ph + 1, n_writes, n_checked);
		$display("classified: %0d long, %0d single, %0d double presses; %0d errors",
			n_long, n_single, n_double, n_err);
		if (n_err == 0) begin
			$display("tb_key_press_classifier OK");
		end else begin
			$display("tb_key_press_classifier NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/kpc_pkg.sv
design/kpc_core.sv
design/key_press_classifier.sv
design/kpc_chk.sv
dv/tb_key_press_classifier.sv
